### hw/rtl/clps_pkg.sv
// Shared types, codes and pin tables for the charlieplexed LED scan driver.
`default_nettype none

package clps_pkg;

   localparam int unsigned NumLeds    = 8;
   localparam int unsigned NumPins    = 4;
   localparam int unsigned LedIdxW    = $clog2(NumLeds);
   localparam int unsigned PhaseBitW  = $clog2(NumLeds);
   localparam int unsigned CodeW      = 4;

   localparam logic [PhaseBitW-1:0] PhaseBitReset = PhaseBitW'(5);
   localparam logic [CodeW-1:0]     LedCodeMin    = CodeW'(1);
   localparam logic [CodeW-1:0]     LedCodeMax    = CodeW'(NumLeds);

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_COMMAND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      LED_OFF   = 2'd0,
      LED_ON    = 2'd1,
      LED_BLINK = 2'd2,
      LED_BOTH  = 2'd3
   } led_state_type;

   typedef struct packed {
      logic       operation;
      logic [5:0] command;
   } req_type;

   typedef struct packed {
      logic [NumPins-1:0] pin_drive_enable;
      logic [NumPins-1:0] pin_level;
      logic               led_lit;
      logic               any_active;
      logic               scan_running;
      logic               command_error;
   } rsp_type;

   typedef struct packed {
      logic                 accept;
      logic                 csr_write;
      logic [PhaseBitW-1:0] csr_data;
   } eng_ctl_type;

   function automatic logic [NumPins-1:0] anode_mask(input logic [LedIdxW-1:0] idx);
      logic [NumPins-1:0] m;
      unique case (idx)
         3'd0:    m = 4'h2;
         3'd1:    m = 4'h1;
         3'd2:    m = 4'h4;
         3'd3:    m = 4'h2;
         3'd4:    m = 4'h8;
         3'd5:    m = 4'h4;
         3'd6:    m = 4'h1;
         3'd7:    m = 4'h8;
         default: m = 4'h0;
      endcase
      return m;
   endfunction

   function automatic logic [NumPins-1:0] cathode_mask(input logic [LedIdxW-1:0] idx);
      logic [NumPins-1:0] m;
      unique case (idx)
         3'd0:    m = 4'h1;
         3'd1:    m = 4'h2;
         3'd2:    m = 4'h2;
         3'd3:    m = 4'h8;
         3'd4:    m = 4'h4;
         3'd5:    m = 4'h8;
         3'd6:    m = 4'h8;
         3'd7:    m = 4'h1;
         default: m = 4'h0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/clps_engine.sv
// LED flag state, scan position, blink timing and per-transaction result logic.
`default_nettype none

module clps_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire clps_pkg::eng_ctl_type ctl,
   input  wire clps_pkg::req_type    req,
   output clps_pkg::rsp_type         result
);
   import clps_pkg::*;

   logic [PhaseBitW-1:0] phase_bit_ff, phase_bit_in;
   logic [NumLeds-1:0]   shine_ff, shine_in;
   logic [NumLeds-1:0]   blink_ff, blink_in;
   logic [NumLeds-1:0]   saved_ff, saved_in;
   logic [NumLeds-1:0]   excl_ff, excl_in;
   logic [7:0]           counter_ff, counter_in;
   logic [LedIdxW-1:0]   index_ff, index_in;
   logic                 running_ff, running_in;

   logic [CodeW-1:0]     code;
   logic [1:0]           st;
   logic                 bad_code;
   logic [LedIdxW-1:0]   led;
   logic [NumLeds-1:0]   led_bit;
   logic [NumLeds-1:0]   lit_mask;
   logic                 lit;

   assign code     = req.command[5:2];
   assign st       = req.command[1:0];
   assign bad_code = (code < LedCodeMin) || (code > LedCodeMax);
   assign led      = LedIdxW'(code - LedCodeMin);
   assign led_bit  = NumLeds'(1) << led;

   always_comb begin
      phase_bit_in = ctl.csr_write ? ctl.csr_data : phase_bit_ff;
      shine_in     = shine_ff;
      blink_in     = blink_ff;
      saved_in     = saved_ff;
      excl_in      = excl_ff;
      counter_in   = counter_ff;
      index_in     = index_ff;
      running_in   = running_ff;
      lit_mask     = '0;
      lit          = 1'b0;
      result       = '0;

      if (ctl.accept) begin
         if (req.operation == OP_COMMAND) begin
            result.command_error = bad_code;
            if (!bad_code) begin
               if (st == LED_ON) begin
                  saved_in = blink_ff;
               end
               // Turning an LED off brings back the blink flags saved by an earlier ON.
               if (st == LED_OFF && saved_ff != '0) begin
                  blink_in = saved_ff;
                  saved_in = '0;
               end else if (st[1]) begin
                  blink_in = blink_ff | led_bit;
               end else begin
                  blink_in = blink_ff & ~led_bit;
               end
               shine_in   = st[0] ? (shine_ff | led_bit) : (shine_ff & ~led_bit);
               running_in = 1'b1;
            end
         end else if (running_ff) begin
            if ((shine_ff | blink_ff) == '0) begin
               running_in = 1'b0;
            end else begin
               if (!counter_ff[phase_bit_ff]) begin
                  excl_in = excl_ff & ~blink_ff;
               end else begin
                  excl_in = '1;
               end
               lit_mask = shine_ff | (blink_ff & excl_in);
               lit      = lit_mask[index_ff];
               result.pin_drive_enable = anode_mask(index_ff) | cathode_mask(index_ff);
               result.pin_level = anode_mask(index_ff) |
                                  (lit ? '0 : cathode_mask(index_ff));
               result.led_lit = lit;
               index_in = index_ff + LedIdxW'(1);
               if (blink_ff != '0) begin
                  counter_in = counter_ff + 8'd1;
               end
            end
         end
         result.any_active   = (shine_in | blink_in) != '0;
         result.scan_running = running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_bit_ff <= PhaseBitReset;
         shine_ff     <= '0;
         blink_ff     <= '0;
         saved_ff     <= '0;
         excl_ff      <= '0;
         counter_ff   <= '0;
         index_ff     <= '0;
         running_ff   <= 1'b0;
      end else begin
         phase_bit_ff <= phase_bit_in;
         shine_ff     <= shine_in;
         blink_ff     <= blink_in;
         saved_ff     <= saved_in;
         excl_ff      <= excl_in;
         counter_ff   <= counter_in;
         index_ff     <= index_in;
         running_ff   <= running_in;
      end
   end

   // A good command always leaves the scan running.
   assert property (@(posedge clock) disable iff (reset)
      ctl.accept && req.operation == OP_COMMAND && !bad_code |=> running_ff)
      else $error("scan not running after a good command");

   // The scan position only moves on a tick that drives pins.
   assert property (@(posedge clock) disable iff (reset)
      index_ff != $past(index_ff) |-> $past(ctl.accept) && $past(result.pin_drive_enable) != '0)
      else $error("scan index moved without a driven tick");

endmodule

`default_nettype wire

### hw/rtl/charlieplex_led_scan_blink.sv
// Top level of the charlieplexed LED scan driver: handshake and result register.
// The result of a transaction is registered and appears on rsp_ in the cycle after it is accepted.
// Throughput: one transaction per cycle unless stalled; one result register, freed as taken.
// A stalled result holds in the result register and stalls the request side.
// Synchronous active-high reset clears all LED flags, stops the scan, sets blink phase bit 5.
`default_nettype none

module charlieplex_led_scan_blink (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire clps_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output clps_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_write_data
);
   import clps_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     eng_result;
   eng_ctl_type eng_ctl;
   logic        accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      eng_ctl.accept    = accept;
      eng_ctl.csr_write = csr_write_enable;
      eng_ctl.csr_data  = csr_write_data;
   end

   clps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (eng_ctl),
      .req    (req_data),
      .result (eng_result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pins are driven only by a tick that leaves the scan running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.scan_running |-> rsp_data_ff.pin_drive_enable == '0)
      else $error("pins driven while the scan is stopped");

   // A driven tick drives exactly one anode and one cathode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones(rsp_data_ff.pin_drive_enable) == 2 ||
                       rsp_data_ff.pin_drive_enable == '0)
      else $error("wrong number of driven pins");

   // A lit LED has its cathode driven low, so not every driven pin is high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.led_lit |->
         rsp_data_ff.pin_drive_enable != '0 &&
         (rsp_data_ff.pin_level & rsp_data_ff.pin_drive_enable) !=
            rsp_data_ff.pin_drive_enable)
      else $error("lit LED without a low cathode");

   // A rejected command carries no scan activity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.command_error |->
         rsp_data_ff.pin_drive_enable == '0 && !rsp_data_ff.led_lit)
      else $error("rejected command produced pin activity");

endmodule

`default_nettype wire
